### rtl/sip_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the sorted-insert priority queue.
// No dependencies; imported by sip_cell and sorted_insert_priority_queue.
package sip_pkg;

    localparam int ValueWidth    = 32;
    localparam int PriorityWidth = 8;
    localparam int FillWidth     = 4;
    localparam int InDataWidth   = 40;
    localparam int OutDataWidth  = 48;

    typedef enum logic [1:0] {
        OP_IDLE   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic {
        ACT_ENQUEUE = 1'b0,
        ACT_DEQUEUE = 1'b1
    } action_t;

    typedef struct packed {
        logic signed [ValueWidth-1:0] value;
        logic [PriorityWidth-1:0]     prio;
    } entry_t;

    typedef struct packed {
        op_t  op;
        logic occupied;
        logic left_stays;
    } cell_ctrl_t;

endpackage

### rtl/sip_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted chain: holds an entry, keeps it, takes the new entry,
// or takes its left or right neighbor's entry. Depends on sip_pkg.
module sip_cell (
    input  logic            aclk,
    input  sip_pkg::cell_ctrl_t ctrl,
    input  sip_pkg::entry_t new_entry,
    input  sip_pkg::entry_t left_entry,
    input  sip_pkg::entry_t right_entry,
    output sip_pkg::entry_t entry,
    output logic            stays
);
    import sip_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // entry at or above the new priority stays in place on insert
    assign stays = ctrl.occupied && (entry_reg.prio >= new_entry.prio);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        unique case (ctrl.op)
            OP_INSERT: begin
                if (stays) begin
                    entry_next = entry_reg;
                end else if (ctrl.left_stays) begin
                    entry_next = new_entry;
                end else begin
                    entry_next = left_entry;
                end
            end
            OP_REMOVE: entry_next = right_entry;
            default:   entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

### rtl/sorted_insert_priority_queue.sv
`timescale 1ns / 1ps
// Sorted-insert priority queue: a row of DEPTH sip_cell slots plus fill count
// and a registered result beat. Depends on sip_pkg and sip_cell.
//
// Takes one beat per cycle while m_tready lets the result register drain: every
// slot compares its priority with the incoming one in parallel and the whole row
// updates together on an enqueue or dequeue; the result beat appears in the cycle after acceptance
// and the input keeps flowing while the result register is drained or empty.
// Equal priorities leave in arrival order. An enqueue into a full queue is
// dropped with status full, a dequeue from an empty queue returns -1 with
// status empty. fill_count carries the low four bits of the entry count.
module sorted_insert_priority_queue #(
    parameter int DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] item_value, [39:32] item_priority
    input  logic [0:0]  s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] out_value, [39:32] out_priority,
                                   // [43:40] fill_count, [47:44] zero
    output logic [1:0]  m_tuser    // [1:0] status
);
    import sip_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          m_tvalid_reg;
    logic [47:0]   m_tdata_reg;
    logic [1:0]    m_tuser_reg;

    entry_t        new_entry;
    entry_t        cell_entry [DEPTH];
    logic          cell_stays [DEPTH];
    cell_ctrl_t    cell_ctrl  [DEPTH];

    logic          accept;
    logic          full;
    logic          empty;
    op_t           op;
    status_t       status;
    logic signed [ValueWidth-1:0] res_value;
    logic [PriorityWidth-1:0]     res_priority;
    logic [CW+FillWidth-1:0]      count_ext;

    assign new_entry.value = s_tdata[ValueWidth-1:0];
    assign new_entry.prio  = s_tdata[ValueWidth+PriorityWidth-1:ValueWidth];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);

    always_comb begin
        op           = OP_IDLE;
        status       = ST_INSERTED;
        res_value    = '0;
        res_priority = '0;
        count_next   = count_reg;
        if (s_tuser[0] == ACT_ENQUEUE) begin
            if (full) begin
                status = ST_FULL;
            end else begin
                status     = ST_INSERTED;
                op         = accept ? OP_INSERT : OP_IDLE;
                count_next = count_reg + CW'(1);
            end
        end else begin
            if (empty) begin
                status    = ST_EMPTY;
                res_value = '1;
            end else begin
                status       = ST_REMOVED;
                op           = accept ? OP_REMOVE : OP_IDLE;
                res_value    = cell_entry[0].value;
                res_priority = cell_entry[0].prio;
                count_next   = count_reg - CW'(1);
            end
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        assign cell_ctrl[i].op       = op;
        assign cell_ctrl[i].occupied = (CW'(i) < count_reg);
        if (i == 0) begin : g_first
            assign cell_ctrl[i].left_stays = 1'b1;
        end else begin : g_rest
            assign cell_ctrl[i].left_stays = cell_stays[i-1];
        end

        sip_cell u_cell (
            .aclk        (aclk),
            .ctrl        (cell_ctrl[i]),
            .new_entry   (new_entry),
            .left_entry  (cell_entry[(i == 0) ? 0 : i-1]),
            .right_entry ((i == DEPTH-1) ? new_entry : cell_entry[(i == DEPTH-1) ? i : i+1]),
            .entry       (cell_entry[i]),
            .stays       (cell_stays[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign count_ext = {{FillWidth{1'b0}}, count_next};

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {4'b0000, count_ext[FillWidth-1:0], res_priority, res_value};
            m_tuser_reg <= status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### sim/sorted_insert_priority_queue_tb.sv
`timescale 1ns / 1ps
// Testbench for sorted_insert_priority_queue: directed and random enqueue/dequeue
// traffic under several idle/stall mixes, checked against a shadow priority queue.
// Depends on sip_pkg and the sorted_insert_priority_queue RTL.
module sorted_insert_priority_queue_tb;
    import sip_pkg::*;

    localparam int QDEPTH    = 8;
    localparam int MAX_CYCLE = 200000;

    typedef struct packed {
        status_t     status;
        logic [3:0]  fill;
        logic [7:0]  prio;
        logic [31:0] value;
    } reply_t;

    class queue_shadow;
        logic [31:0] slot_value[QDEPTH];
        logic [7:0]  slot_prio[QDEPTH];
        int unsigned fill;
        reply_t      due_results[$];
        int          errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function void take_request(action_t act, logic [31:0] val, logic [7:0] pri);
            reply_t r;
            int unsigned pos;
            r = '0;
            if (act == ACT_ENQUEUE) begin
                if (fill >= QDEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < fill && slot_prio[pos] >= pri) pos++;
                    for (int k = fill; k > pos; k--) begin
                        slot_value[k] = slot_value[k-1];
                        slot_prio[k]  = slot_prio[k-1];
                    end
                    slot_value[pos] = val;
                    slot_prio[pos]  = pri;
                    fill++;
                    r.status = ST_INSERTED;
                end
            end else begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                    r.value  = 32'hFFFF_FFFF;
                end else begin
                    r.status = ST_REMOVED;
                    r.value  = slot_value[0];
                    r.prio   = slot_prio[0];
                    for (int k = 1; k < fill; k++) begin
                        slot_value[k-1] = slot_value[k];
                        slot_prio[k-1]  = slot_prio[k];
                    end
                    fill--;
                end
            end
            r.fill = fill[3:0];
            due_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            end
        endfunction

        function void check_reply(logic [47:0] data, logic [1:0] user);
            reply_t r;
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat: expected none, got tuser %h tdata %h",
                         $time, user, data);
                return;
            end
            r = due_results.pop_front();
            compare_field("status", 32'(r.status), 32'(user));
            compare_field("out_value", r.value, data[31:0]);
            compare_field("out_priority", 32'(r.prio), 32'(data[39:32]));
            compare_field("fill_count", 32'(r.fill), 32'(data[43:40]));
            compare_field("pad", 32'd0, 32'(data[47:44]));
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int unsigned cycle_count   = 0;
    queue_shadow shadow;

    sorted_insert_priority_queue #(.DEPTH(QDEPTH)) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // inputs only move at posedge, so negedge sees what the next edge will take
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready) shadow.check_reply(m_tdata, m_tuser);
    end

    task automatic send_beat(input action_t act, input logic [31:0] val,
                             input logic [7:0] pri);
        logic taken;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pri, val};
        s_tuser  <= act;
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
        shadow.take_request(act, val, pri);
    endtask

    task automatic random_phase(input int idle_pct, input int stall, input int count);
        int      enq_pct;
        action_t act;
        logic [7:0] pri;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        enq_pct       = 50;
        for (int i = 0; i < count; i++) begin
            // bursts biased toward filling or draining reach full and empty often
            if (i % 16 == 0) begin
                case ($urandom_range(2))
                    0: enq_pct = 80;
                    1: enq_pct = 20;
                    default: enq_pct = 50;
                endcase
            end
            act = ($urandom_range(99) < enq_pct) ? ACT_ENQUEUE : ACT_DEQUEUE;
            case ($urandom_range(3))
                0: pri = 8'($urandom_range(3));
                1: pri = $urandom_range(1) ? 8'hFF : 8'h00;
                default: pri = 8'($urandom);
            endcase
            send_beat(act, $urandom, pri);
        end
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= ACT_ENQUEUE;
        m_tready <= 1'b0;
        shadow = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty, extremes, ties, full, drain, empty again
        send_beat(ACT_DEQUEUE, 32'h0000_0000, 8'h00);
        send_beat(ACT_ENQUEUE, 32'h7FFF_FFFF, 8'h00);
        send_beat(ACT_ENQUEUE, 32'h8000_0000, 8'hFF);
        send_beat(ACT_ENQUEUE, 32'h0000_0000, 8'h80);
        send_beat(ACT_ENQUEUE, 32'hFFFF_FFFF, 8'h80);
        send_beat(ACT_ENQUEUE, 32'h0000_0001, 8'h00);
        send_beat(ACT_ENQUEUE, 32'h5555_5555, 8'hFF);
        send_beat(ACT_ENQUEUE, 32'hAAAA_AAAA, 8'h01);
        send_beat(ACT_ENQUEUE, 32'h1234_5678, 8'hC8);
        send_beat(ACT_ENQUEUE, 32'hDEAD_BEEF, 8'h7F);
        send_beat(ACT_ENQUEUE, 32'hFFFF_FFFF, 8'hFF);
        for (int i = 0; i < QDEPTH; i++) send_beat(ACT_DEQUEUE, 32'hFFFF_FFFF, 8'hFF);
        send_beat(ACT_DEQUEUE, 32'h0000_0000, 8'h00);
        send_beat(ACT_ENQUEUE, 32'hCAFE_F00D, 8'h00);
        send_beat(ACT_DEQUEUE, 32'h0000_0000, 8'h00);
        send_beat(ACT_ENQUEUE, 32'h0F0F_0F0F, 8'hAA);
        send_beat(ACT_DEQUEUE, 32'h0000_0000, 8'h55);

        random_phase(0, 0, 125);
        random_phase(76, 0, 125);
        random_phase(0, 76, 125);
        random_phase(28, 28, 125);

        s_tvalid <= 1'b0;
        while (shadow.due_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (shadow.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
